### rtl/core/rtms_pkg.sv
// shared types, constants and helpers for the raster tile max-sum centroid block
package rtms_pkg;

  localparam int unsigned COORD_BITS     = 12;
  localparam int unsigned MAX_TILE_COLS  = 16;
  localparam int unsigned TILE_IDX_W     = 6;
  localparam int unsigned TILE_ROW_W     = 12;
  localparam int unsigned TILE_COL_OUT_W = 4;
  localparam int unsigned SIZE_W         = 13;
  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned SUM_W          = 64;
  localparam int unsigned ADDR_W         = 5;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam logic [SIZE_W-1:0]          SIZE_MAX     = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0]          SIZE_RESET   = SIZE_W'(1);
  localparam logic signed [SAMPLE_W-1:0] NODATA_RESET = -32'sd2559744;

  typedef enum logic [2:0] {
    REG_RASTER_ROWS = 3'd0,
    REG_RASTER_COLS = 3'd1,
    REG_TILE_HEIGHT = 3'd2,
    REG_TILE_WIDTH  = 3'd3,
    REG_NODATA_CODE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0]          rows;
    logic [SIZE_W-1:0]          cols;
    logic [SIZE_W-1:0]          tile_h;
    logic [SIZE_W-1:0]          tile_w;
    logic signed [SAMPLE_W-1:0] nodata;
  } cfg_t;

  typedef struct packed {
    logic                       valid_sample;
    logic signed [SAMPLE_W-1:0] sample;
    logic [TILE_IDX_W-1:0]      tile_col;
    logic [COORD_BITS-1:0]      prow;
    logic [COORD_BITS-1:0]      pcol;
    logic [TILE_ROW_W-1:0]      tile_row;
    logic                       tile_done;
    logic                       frame_done;
  } item_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

endpackage

### rtl/core/rtms_front.sv
// front end: raster position tracking and tile classification of each sample
module rtms_front #(
  parameter int unsigned MAX_TILE_COLS = rtms_pkg::MAX_TILE_COLS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [rtms_pkg::SAMPLE_W-1:0] sample,
  input  rtms_pkg::cfg_t                       cfg,
  input  logic                                 full,
  output logic                                 push,
  output rtms_pkg::item_t                      item
);

  localparam int unsigned IDX_W = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TILE_COLS - 1);
  localparam int unsigned CW = rtms_pkg::COORD_BITS;
  localparam int unsigned SW = rtms_pkg::SIZE_W;

  logic [CW-1:0] pixel_row, pixel_row_next;
  logic [CW-1:0] pixel_col, pixel_col_next;
  logic [CW-1:0] row_in_tile, row_in_tile_next;
  logic [CW-1:0] col_in_tile, col_in_tile_next;
  logic [IDX_W-1:0] tile_col_index, tile_col_index_next;
  logic [rtms_pkg::TILE_ROW_W-1:0] tile_row_index, tile_row_index_next;

  logic [SW-1:0] rows, cols, th, tw;
  logic row_end, col_end, tile_col_end, tile_row_end;

  assign rows = rtms_pkg::clamp_size(cfg.rows);
  assign cols = rtms_pkg::clamp_size(cfg.cols);
  assign th   = rtms_pkg::clamp_size(cfg.tile_h);
  assign tw   = rtms_pkg::clamp_size(cfg.tile_w);

  assign row_end = (SW'(pixel_col) + SW'(1)) >= cols;
  assign col_end = (SW'(pixel_row) + SW'(1)) >= rows;
  assign tile_col_end = row_end ||
                        (((SW'(col_in_tile) + SW'(1)) >= tw) && (tile_col_index != LAST_IDX));
  assign tile_row_end = col_end || ((SW'(row_in_tile) + SW'(1)) >= th);

  assign push = start && !full;

  always_comb begin
    item.valid_sample = (sample != cfg.nodata);
    item.sample       = sample;
    item.tile_col     = rtms_pkg::TILE_IDX_W'(tile_col_index);
    item.prow         = pixel_row;
    item.pcol         = pixel_col;
    item.tile_row     = tile_row_index;
    item.tile_done    = tile_col_end && tile_row_end;
    item.frame_done   = row_end && col_end;
  end

  always_comb begin
    pixel_row_next      = pixel_row;
    pixel_col_next      = pixel_col;
    row_in_tile_next    = row_in_tile;
    col_in_tile_next    = col_in_tile;
    tile_col_index_next = tile_col_index;
    tile_row_index_next = tile_row_index;
    if (row_end && col_end) begin
      pixel_row_next      = '0;
      pixel_col_next      = '0;
      row_in_tile_next    = '0;
      col_in_tile_next    = '0;
      tile_col_index_next = '0;
      tile_row_index_next = '0;
    end else if (row_end) begin
      pixel_col_next      = '0;
      col_in_tile_next    = '0;
      tile_col_index_next = '0;
      pixel_row_next      = pixel_row + CW'(1);
      if (tile_row_end) begin
        row_in_tile_next    = '0;
        tile_row_index_next = tile_row_index + rtms_pkg::TILE_ROW_W'(1);
      end else begin
        row_in_tile_next = row_in_tile + CW'(1);
      end
    end else begin
      pixel_col_next = pixel_col + CW'(1);
      if (tile_col_end) begin
        col_in_tile_next    = '0;
        tile_col_index_next = tile_col_index + IDX_W'(1);
      end else begin
        col_in_tile_next = col_in_tile + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_row      <= '0;
      pixel_col      <= '0;
      row_in_tile    <= '0;
      col_in_tile    <= '0;
      tile_col_index <= '0;
      tile_row_index <= '0;
    end else if (push) begin
      pixel_row      <= pixel_row_next;
      pixel_col      <= pixel_col_next;
      row_in_tile    <= row_in_tile_next;
      col_in_tile    <= col_in_tile_next;
      tile_col_index <= tile_col_index_next;
      tile_row_index <= tile_row_index_next;
    end
  end

endmodule

### rtl/core/rtms_queue.sv
// short queue of classified samples between front and back
module rtms_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rtms_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output rtms_pkg::item_t pop_item
);

  localparam int unsigned DEPTH = rtms_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rtms_pkg::item_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !do_pop) count <= count + CNT_W'(1);
      else if (!push && do_pop) count <= count - CNT_W'(1);
    end
  end

endmodule

### rtl/core/rtms_back.sv
// back end: per tile column accumulation, tile competition and frame result
module rtms_back #(
  parameter int unsigned MAX_TILE_COLS = rtms_pkg::MAX_TILE_COLS
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  input  rtms_pkg::item_t                          in_item,
  output logic                                     done,
  output logic                                     found,
  output logic [rtms_pkg::TILE_ROW_W-1:0]          best_tile_row,
  output logic [rtms_pkg::TILE_COL_OUT_W-1:0]      best_tile_col,
  output logic signed [rtms_pkg::SUM_W-1:0]        best_sum,
  output logic [rtms_pkg::COORD_BITS-1:0]          centroid_row,
  output logic [rtms_pkg::COORD_BITS-1:0]          centroid_col
);

  localparam int unsigned IDX_W = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
  localparam int unsigned CW = rtms_pkg::COORD_BITS;
  localparam int unsigned SUMW = rtms_pkg::SUM_W;
  localparam int unsigned SMPW = rtms_pkg::SAMPLE_W;

  typedef struct packed {
    logic                      has_valid;
    logic signed [SUMW-1:0]    sum;
    logic [CW-1:0]             min_row;
    logic [CW-1:0]             max_row;
    logic [CW-1:0]             min_col;
    logic [CW-1:0]             max_col;
    logic [rtms_pkg::TILE_ROW_W-1:0] tile_row;
    logic [IDX_W-1:0]          tile_col;
  } tile_t;

  logic signed [SUMW-1:0] acc_sum     [MAX_TILE_COLS];
  logic                   acc_has_valid [MAX_TILE_COLS];
  logic [CW-1:0]          acc_min_row [MAX_TILE_COLS];
  logic [CW-1:0]          acc_max_row [MAX_TILE_COLS];
  logic [CW-1:0]          acc_min_col [MAX_TILE_COLS];
  logic [CW-1:0]          acc_max_col [MAX_TILE_COLS];

  logic [IDX_W-1:0] k;
  tile_t upd;

  logic  fin_go, fin_frame;
  tile_t fin;

  logic                   best_valid;
  logic signed [SUMW-1:0] best_total;
  logic [CW-1:0]          best_centre_row, best_centre_col;
  logic [rtms_pkg::TILE_ROW_W-1:0] best_tile_r;
  logic [IDX_W-1:0]       best_tile_c;

  logic                   win;
  logic                   nb_valid;
  logic signed [SUMW-1:0] nb_total;
  logic [CW-1:0]          nb_centre_row, nb_centre_col;
  logic [rtms_pkg::TILE_ROW_W-1:0] nb_tile_r;
  logic [IDX_W-1:0]       nb_tile_c;
  logic [CW:0]            span_row, span_col;

  assign k = in_item.tile_col[IDX_W-1:0];

  // read-modify-write of the current tile column entry
  always_comb begin
    upd.has_valid = acc_has_valid[k];
    upd.sum       = acc_sum[k];
    upd.min_row   = acc_min_row[k];
    upd.max_row   = acc_max_row[k];
    upd.min_col   = acc_min_col[k];
    upd.max_col   = acc_max_col[k];
    upd.tile_row  = in_item.tile_row;
    upd.tile_col  = k;
    if (in_item.valid_sample) begin
      upd.has_valid = 1'b1;
      upd.sum = acc_sum[k] + {{(SUMW-SMPW){in_item.sample[SMPW-1]}}, in_item.sample};
      if (in_item.prow < acc_min_row[k]) upd.min_row = in_item.prow;
      if (in_item.prow > acc_max_row[k]) upd.max_row = in_item.prow;
      if (in_item.pcol < acc_min_col[k]) upd.min_col = in_item.pcol;
      if (in_item.pcol > acc_max_col[k]) upd.max_col = in_item.pcol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TILE_COLS; i++) begin
        acc_sum[i]       <= '0;
        acc_has_valid[i] <= 1'b0;
        acc_min_row[i]   <= '1;
        acc_max_row[i]   <= '0;
        acc_min_col[i]   <= '1;
        acc_max_col[i]   <= '0;
      end
      fin_go    <= 1'b0;
      fin_frame <= 1'b0;
    end else begin
      fin_go    <= in_valid && in_item.tile_done;
      fin_frame <= in_valid && in_item.frame_done;
      if (in_valid) begin
        if (in_item.frame_done) begin
          for (int i = 0; i < MAX_TILE_COLS; i++) begin
            acc_sum[i]       <= '0;
            acc_has_valid[i] <= 1'b0;
            acc_min_row[i]   <= '1;
            acc_max_row[i]   <= '0;
            acc_min_col[i]   <= '1;
            acc_max_col[i]   <= '0;
          end
        end else if (in_item.tile_done) begin
          acc_sum[k]       <= '0;
          acc_has_valid[k] <= 1'b0;
          acc_min_row[k]   <= '1;
          acc_max_row[k]   <= '0;
          acc_min_col[k]   <= '1;
          acc_max_col[k]   <= '0;
        end else begin
          acc_sum[k]       <= upd.sum;
          acc_has_valid[k] <= upd.has_valid;
          acc_min_row[k]   <= upd.min_row;
          acc_max_row[k]   <= upd.max_row;
          acc_min_col[k]   <= upd.min_col;
          acc_max_col[k]   <= upd.max_col;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_item.tile_done) begin
      fin <= upd;
    end
  end

  // tile competition
  assign win = fin.has_valid && (!best_valid || (fin.sum > best_total));
  assign span_row = (CW+1)'(fin.max_row) - (CW+1)'(fin.min_row) + (CW+1)'(1);
  assign span_col = (CW+1)'(fin.max_col) - (CW+1)'(fin.min_col) + (CW+1)'(1);

  always_comb begin
    nb_valid      = best_valid;
    nb_total      = best_total;
    nb_centre_row = best_centre_row;
    nb_centre_col = best_centre_col;
    nb_tile_r     = best_tile_r;
    nb_tile_c     = best_tile_c;
    if (fin_go && win) begin
      nb_valid      = 1'b1;
      nb_total      = fin.sum;
      nb_centre_row = fin.min_row + span_row[CW:1];
      nb_centre_col = fin.min_col + span_col[CW:1];
      nb_tile_r     = fin.tile_row;
      nb_tile_c     = fin.tile_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid      <= 1'b0;
      best_total      <= '0;
      best_centre_row <= '0;
      best_centre_col <= '0;
      best_tile_r     <= '0;
      best_tile_c     <= '0;
      done            <= 1'b0;
    end else begin
      done <= fin_frame;
      if (fin_frame) begin
        best_valid      <= 1'b0;
        best_total      <= '0;
        best_centre_row <= '0;
        best_centre_col <= '0;
        best_tile_r     <= '0;
        best_tile_c     <= '0;
      end else begin
        best_valid      <= nb_valid;
        best_total      <= nb_total;
        best_centre_row <= nb_centre_row;
        best_centre_col <= nb_centre_col;
        best_tile_r     <= nb_tile_r;
        best_tile_c     <= nb_tile_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_frame) begin
      found         <= nb_valid;
      best_tile_row <= nb_valid ? nb_tile_r : '0;
      best_tile_col <= nb_valid ?
                       rtms_pkg::TILE_COL_OUT_W'(rtms_pkg::TILE_IDX_W'(nb_tile_c)) : '0;
      best_sum      <= nb_valid ? nb_total : '0;
      centroid_row  <= nb_valid ? nb_centre_row : '0;
      centroid_col  <= nb_valid ? nb_centre_col : '0;
    end
  end

endmodule

### rtl/core/raster_tile_max_sum_centroid.sv
// top level: register port, front end, sample queue and accumulation back end
// result path: a frame's last sample passes through the queue, then the fin_frame register, then the done register
// throughput: one sample per cycle; busy never rises, the back end drains the queue every cycle
// done is a one-cycle strobe; the receiver cannot stall
// reset clears position counters, all tile accumulators and the best tile, and sets the registers to their reset values
module raster_tile_max_sum_centroid #(
  parameter int unsigned MAX_TILE_COLS = rtms_pkg::MAX_TILE_COLS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [rtms_pkg::SAMPLE_W-1:0]  sample,
  output logic                                  done,
  output logic                                  found,
  output logic [rtms_pkg::TILE_ROW_W-1:0]       best_tile_row,
  output logic [rtms_pkg::TILE_COL_OUT_W-1:0]   best_tile_col,
  output logic signed [rtms_pkg::SUM_W-1:0]     best_sum,
  output logic [rtms_pkg::COORD_BITS-1:0]       centroid_row,
  output logic [rtms_pkg::COORD_BITS-1:0]       centroid_col,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rtms_pkg::ADDR_W-1:0]           paddr,
  input  logic [rtms_pkg::DATA_W-1:0]           pwdata,
  output logic [rtms_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);

  localparam int unsigned SW = rtms_pkg::SIZE_W;
  localparam int unsigned DW = rtms_pkg::DATA_W;

  rtms_pkg::cfg_t  cfg;
  rtms_pkg::item_t push_item, pop_item;
  logic push, full, not_empty;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rtms_pkg::ADDR_W-1:2];
  assign busy    = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows   <= rtms_pkg::SIZE_RESET;
      cfg.cols   <= rtms_pkg::SIZE_RESET;
      cfg.tile_h <= rtms_pkg::SIZE_RESET;
      cfg.tile_w <= rtms_pkg::SIZE_RESET;
      cfg.nodata <= rtms_pkg::NODATA_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        rtms_pkg::REG_RASTER_ROWS: cfg.rows   <= pwdata[SW-1:0];
        rtms_pkg::REG_RASTER_COLS: cfg.cols   <= pwdata[SW-1:0];
        rtms_pkg::REG_TILE_HEIGHT: cfg.tile_h <= pwdata[SW-1:0];
        rtms_pkg::REG_TILE_WIDTH:  cfg.tile_w <= pwdata[SW-1:0];
        rtms_pkg::REG_NODATA_CODE: cfg.nodata <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rtms_pkg::REG_RASTER_ROWS: prdata = DW'(cfg.rows);
      rtms_pkg::REG_RASTER_COLS: prdata = DW'(cfg.cols);
      rtms_pkg::REG_TILE_HEIGHT: prdata = DW'(cfg.tile_h);
      rtms_pkg::REG_TILE_WIDTH:  prdata = DW'(cfg.tile_w);
      rtms_pkg::REG_NODATA_CODE: prdata = cfg.nodata;
      default:                   prdata = '0;
    endcase
  end

  rtms_front #(
    .MAX_TILE_COLS(MAX_TILE_COLS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sample (sample),
    .cfg    (cfg),
    .full   (full),
    .push   (push),
    .item   (push_item)
  );

  rtms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (not_empty),
    .full      (full),
    .not_empty (not_empty),
    .pop_item  (pop_item)
  );

  rtms_back #(
    .MAX_TILE_COLS(MAX_TILE_COLS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (not_empty),
    .in_item       (pop_item),
    .done          (done),
    .found         (found),
    .best_tile_row (best_tile_row),
    .best_tile_col (best_tile_col),
    .best_sum      (best_sum),
    .centroid_row  (centroid_row),
    .centroid_col  (centroid_col)
  );

endmodule
